// ===== hdl/rational_add_reduce_core_assert.svh =====
// Assertion macros for the rational add and reduce core.
// Used by the checker module; depends on nothing else.
`ifndef RATIONAL_ADD_REDUCE_CORE_ASSERT_SVH
`define RATIONAL_ADD_REDUCE_CORE_ASSERT_SVH
`define RAR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/rar_pkg.sv =====
// Shared types and constants for the rational add and reduce core.
// No dependencies.
`timescale 1ns / 1ps
package rar_pkg;
    localparam int OPERAND_BITS = 32;
    localparam int WIDE_BITS    = 64;
    localparam int DEN_BITS     = 62;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_GCD1  = 3'd2,
        OP_LCM   = 3'd3,
        OP_SCALE = 3'd4,
        OP_SUM   = 3'd5,
        OP_GCD2  = 3'd6,
        OP_RED   = 3'd7
    } t_op;

    typedef struct packed {
        t_op  op;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic bad;
    } t_status;
endpackage

// ===== hdl/rar_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rar_pkg.
`timescale 1ns / 1ps
module rar_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rar_pkg::WIDE_BITS-1:0] i_dividend,
    input  logic [rar_pkg::WIDE_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [rar_pkg::WIDE_BITS-1:0] o_quot,
    output logic [rar_pkg::WIDE_BITS-1:0] o_rem
);
    localparam int W = rar_pkg::WIDE_BITS;
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_q, r_d;
    logic [W:0]    r_r;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    n_shift, n_diff;

    assign n_shift = {r_r[W-1:0], r_q[W-1]};
    assign n_diff  = n_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_r    <= '0;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (n_diff[W]) begin
                    r_r <= n_shift;
                    r_q <= {r_q[W-2:0], 1'b0};
                end else begin
                    r_r <= n_diff;
                    r_q <= {r_q[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[W-1:0];
endmodule

// ===== hdl/rar_datapath.sv =====
// Datapath: operand registers, divider and multiplier for the fraction sum.
// Depends on rar_pkg and rar_div.
`timescale 1ns / 1ps
module rar_datapath #(
    parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rar_pkg::t_cmd                 i_cmd,
    input  logic [OPERAND_BITS-1:0]       i_a_num,
    input  logic [OPERAND_BITS-1:0]       i_a_den,
    input  logic [OPERAND_BITS-1:0]       i_b_num,
    input  logic [OPERAND_BITS-1:0]       i_b_den,
    output rar_pkg::t_status              o_status,
    output logic [rar_pkg::WIDE_BITS-1:0] o_sum_num,
    output logic [rar_pkg::DEN_BITS-1:0]  o_sum_den
);
    localparam int W = rar_pkg::WIDE_BITS;
    localparam int H = W / 2;

    logic [W-1:0] r_an, r_ad, r_bn, r_bd, r_x, r_y, r_l, r_mag, r_ta;
    logic         r_an_neg, r_ad_neg, r_bn_neg, r_bd_neg, r_neg, r_sub, r_phase;
    logic         r_start, r_wait;
    logic [1:0]   r_sub_step;
    logic [W-1:0] r_div_a, r_div_b;
    logic         div_done;
    logic [W-1:0] div_q, div_r;
    logic [W-1:0] mul_p;
    logic [W-1:0] r_mul_a, r_mul_b;
    logic [W-1:0] sa, sb, sum;

    function automatic logic [W-1:0] mag_of(input logic [OPERAND_BITS-1:0] v);
        logic [OPERAND_BITS-1:0] m;
        m = v[OPERAND_BITS-1] ? (~v + 1'b1) : v;
        return W'(m);
    endfunction

    rar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // operands stay below 2^32, so one 32x32 product
    assign mul_p = r_mul_a[H-1:0] * r_mul_b[H-1:0];
    assign sa    = (r_an_neg ^ r_ad_neg) ? (~r_ta + 1'b1) : r_ta;
    assign sb    = (r_bn_neg ^ r_bd_neg) ? (~mul_p + 1'b1) : mul_p;
    assign sum   = sa + sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= 1'b0;
            r_wait     <= 1'b0;
            r_sub_step <= '0;
        end else begin
            r_start <= 1'b0;
            case (i_cmd.op)
                rar_pkg::OP_LOAD: begin
                    r_an <= mag_of(i_a_num);  r_an_neg <= i_a_num[OPERAND_BITS-1];
                    r_ad <= mag_of(i_a_den);  r_ad_neg <= i_a_den[OPERAND_BITS-1];
                    r_bn <= mag_of(i_b_num);  r_bn_neg <= i_b_num[OPERAND_BITS-1];
                    r_bd <= mag_of(i_b_den);  r_bd_neg <= i_b_den[OPERAND_BITS-1];
                    r_x  <= mag_of(i_a_den);
                    r_y  <= mag_of(i_b_den);
                    r_wait <= 1'b0;
                end
                rar_pkg::OP_GCD1, rar_pkg::OP_GCD2: begin
                    // y := y mod x, swap, until x is zero
                    if (!r_wait && r_x != '0) begin
                        r_div_a <= r_y;
                        r_div_b <= r_x;
                        r_start <= 1'b1;
                        r_wait  <= 1'b1;
                    end else if (div_done) begin
                        r_y    <= r_x;
                        r_x    <= div_r;
                        r_wait <= 1'b0;
                    end
                end
                rar_pkg::OP_LCM: begin
                    // l = (ad / g) * bd
                    if (!r_wait) begin
                        r_div_a <= r_ad;
                        r_div_b <= r_y;
                        r_start <= 1'b1;
                        r_wait  <= 1'b1;
                        r_sub_step <= '0;
                    end else if (div_done) begin
                        r_mul_a <= div_q;
                        r_mul_b <= r_bd;
                        r_sub_step <= 2'd1;
                    end else if (r_sub_step == 2'd1) begin
                        r_l <= mul_p;
                        r_sub_step <= 2'd2;
                    end
                end
                rar_pkg::OP_SCALE: begin
                    // ta = an * (l/ad), then operands for tb = bn * (l/bd)
                    if (!r_wait) begin
                        r_div_a <= r_l;
                        r_div_b <= r_phase ? r_bd : r_ad;
                        r_start <= 1'b1;
                        r_wait  <= 1'b1;
                        r_sub_step <= '0;
                    end else if (div_done) begin
                        r_mul_a <= div_q;
                        r_mul_b <= r_phase ? r_bn : r_an;
                        r_sub_step <= 2'd1;
                    end else if (r_sub_step == 2'd1) begin
                        if (!r_phase) begin
                            r_ta <= mul_p;
                        end
                        r_sub_step <= 2'd2;
                    end
                end
                rar_pkg::OP_SUM: begin
                    r_neg <= sum[W-1];
                    r_mag <= sum[W-1] ? (~sum + 1'b1) : sum;
                    r_x   <= sum[W-1] ? (~sum + 1'b1) : sum;
                    r_y   <= r_l;
                    r_wait <= 1'b0;
                end
                rar_pkg::OP_RED: begin
                    // mag / g, then l / g
                    if (!r_wait) begin
                        r_div_a <= r_sub ? r_l : r_mag;
                        r_div_b <= r_y;
                        r_start <= 1'b1;
                        r_wait  <= 1'b1;
                    end else if (div_done) begin
                        if (r_sub) begin
                            r_l <= div_q;
                        end else begin
                            r_mag <= div_q;
                        end
                        r_sub_step <= 2'd3;
                    end
                end
                default: begin
                    r_wait <= 1'b0;
                end
            endcase
            if (i_cmd.step) begin
                r_wait <= 1'b0;
                r_sub_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_sub   <= 1'b0;
        end else if (i_cmd.op == rar_pkg::OP_LOAD) begin
            r_phase <= 1'b0;
            r_sub   <= 1'b0;
        end else if (i_cmd.step && i_cmd.op == rar_pkg::OP_SCALE) begin
            r_phase <= ~r_phase;
        end else if (i_cmd.step && i_cmd.op == rar_pkg::OP_RED) begin
            r_sub <= ~r_sub;
        end
    end

    always_comb begin
        o_status.done = 1'b0;
        o_status.bad  = (r_ad == '0) || (r_bd == '0);
        case (i_cmd.op)
            rar_pkg::OP_GCD1, rar_pkg::OP_GCD2: o_status.done = !r_wait && r_x == '0;
            rar_pkg::OP_LCM, rar_pkg::OP_SCALE: o_status.done = r_sub_step == 2'd2;
            rar_pkg::OP_RED:                    o_status.done = r_sub_step == 2'd3;
            default:                            o_status.done = 1'b1;
        endcase
    end
    assign o_sum_num = r_neg ? (~r_mag + 1'b1) : r_mag;
    assign o_sum_den = r_l[rar_pkg::DEN_BITS-1:0];
endmodule

// ===== hdl/rar_ctrl.sv =====
// Controller state machine sequencing the fraction sum datapath.
// Depends on rar_pkg.
`timescale 1ns / 1ps
module rar_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rar_pkg::t_status i_status,
    output rar_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_valid,
    output logic             o_bad
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_GCD1, S_LCM, S_SCA, S_SCB, S_SUM, S_GCD2,
        S_RED1, S_RED2, S_OUT
    } t_state;

    t_state r_state;
    logic   r_valid, r_bad;

    always_comb begin
        o_cmd.op   = rar_pkg::OP_NONE;
        o_cmd.step = 1'b0;
        case (r_state)
            S_IDLE:  o_cmd.op = i_start ? rar_pkg::OP_LOAD : rar_pkg::OP_NONE;
            S_GCD1:  o_cmd.op = rar_pkg::OP_GCD1;
            S_LCM:   o_cmd.op = rar_pkg::OP_LCM;
            S_SCA:   o_cmd.op = rar_pkg::OP_SCALE;
            S_SCB:   o_cmd.op = rar_pkg::OP_SCALE;
            S_SUM:   o_cmd.op = rar_pkg::OP_SUM;
            S_GCD2:  o_cmd.op = rar_pkg::OP_GCD2;
            S_RED1:  o_cmd.op = rar_pkg::OP_RED;
            S_RED2:  o_cmd.op = rar_pkg::OP_RED;
            default: o_cmd.op = rar_pkg::OP_NONE;
        endcase
        if (r_state inside {S_LCM, S_SCA, S_SCB, S_RED1, S_RED2}) begin
            o_cmd.step = i_status.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE:  if (i_start) r_state <= S_CHECK;
                S_CHECK: r_state <= i_status.bad ? S_OUT : S_GCD1;
                S_GCD1:  if (i_status.done) r_state <= S_LCM;
                S_LCM:   if (i_status.done) r_state <= S_SCA;
                S_SCA:   if (i_status.done) r_state <= S_SCB;
                S_SCB:   if (i_status.done) r_state <= S_SUM;
                S_SUM:   r_state <= S_GCD2;
                S_GCD2:  if (i_status.done) r_state <= S_RED1;
                S_RED1:  if (i_status.done) r_state <= S_RED2;
                S_RED2:  if (i_status.done) r_state <= S_OUT;
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_bad   <= i_status.bad;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_valid;
    assign o_bad   = r_bad;
endmodule

// ===== hdl/rational_add_reduce_core.sv =====
// Timing per item is set by the iterative divider: each remainder step of the two
// gcd loops runs one division, and the five quotient divisions come on top. A zero
// denominator skips straight from the check to the output state.
// Throughput: one item at a time; start is taken only while busy is low.
// Reset: synchronous active-low i_rst_n returns the controller to idle.
// The receiver cannot stall: each result shows for one cycle on o_valid.
`timescale 1ns / 1ps
module rational_add_reduce_core #(
    parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [OPERAND_BITS-1:0]       i_a_num,
    input  logic [OPERAND_BITS-1:0]       i_a_den,
    input  logic [OPERAND_BITS-1:0]       i_b_num,
    input  logic [OPERAND_BITS-1:0]       i_b_den,
    output logic                          o_valid,
    output logic [rar_pkg::WIDE_BITS-1:0] o_sum_num,
    output logic [rar_pkg::DEN_BITS-1:0]  o_sum_den,
    output logic                          o_bad_input
);
    rar_pkg::t_cmd    cmd;
    rar_pkg::t_status status;
    logic             valid, bad;
    logic [rar_pkg::WIDE_BITS-1:0] num;
    logic [rar_pkg::DEN_BITS-1:0]  den;

    rar_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (valid),
        .o_bad    (bad)
    );

    rar_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_status  (status),
        .o_sum_num (num),
        .o_sum_den (den)
    );

    // zero sum leaves l reduced by itself, so the denominator is one already
    assign o_valid     = valid;
    assign o_bad_input = bad;
    assign o_sum_num   = bad ? '0 : num;
    assign o_sum_den   = bad ? rar_pkg::DEN_BITS'(1) : den;
endmodule

// ===== hdl/rar_checker.sv =====
// Port-level checker for the rational add and reduce core, with its bind.
// Depends on rar_pkg and rational_add_reduce_core_assert.svh.
`timescale 1ns / 1ps
`include "rational_add_reduce_core_assert.svh"
module rar_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [rar_pkg::WIDE_BITS-1:0] o_sum_num,
    input logic [rar_pkg::DEN_BITS-1:0]  o_sum_den,
    input logic                          o_bad_input
);
    `RAR_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `RAR_ASSERT_IMPL(a_den_pos, i_clk, i_rst_n, o_valid, o_sum_den != '0)
    `RAR_ASSERT_IMPL(a_bad_zero, i_clk, i_rst_n, o_valid && o_bad_input,
        o_sum_num == '0 && o_sum_den == rar_pkg::DEN_BITS'(1))
    `RAR_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
endmodule

bind rational_add_reduce_core rar_checker u_rar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_sum_num   (o_sum_num),
    .o_sum_den   (o_sum_den),
    .o_bad_input (o_bad_input)
);
